// File: design/kvt_pkg.sv
// Package with the shared types, sizes and operation codes of the key-value table.
package kvt_pkg;

    // Number of entries the table can hold.
    localparam int CAPACITY = 8;
    // Width of the entry counter, wide enough to hold CAPACITY itself.
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int ECNT_W   = 4;

    typedef logic [CNT_W-1:0] t_count;

    // Operation codes of a request; the last code is unused and changes nothing.
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Request payload.
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] value_out;
        logic                    full_res;
        logic [ECNT_W-1:0]       entry_count;
        logic                    empty_res;
    } t_rsp;

    // Per-cycle commands broadcast from the controller to every cell.
    typedef struct packed {
        logic cmp_en;      // Latch the key comparison of an accepted request.
        logic add_update;  // Overwrite the value of the matching cell.
        logic append;      // Load a new entry into the tail cell.
        logic shift;       // Remove: cells at or after the match take their neighbor.
    } t_cell_ctl;

endpackage

// File: design/kvt_if.sv
// Handshake interfaces for the request and response channels.
interface kvt_req_if;
    logic          valid;
    logic          ready;
    kvt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kvt_rsp_if;
    logic          valid;
    logic          ready;
    kvt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/key_value_table_compacting_top.sv
// Top level of the key-value table: controller, row of cells and response register.
//
//  Channel   Dir   Modport  Payload
//  i_req     in    sink     operation, key, value
//  o_rsp     out   source   found, value_out, full_res, entry_count, empty_res
//
// Each transaction first compares the key in every cell when the request is accepted;
// the table is then updated and the response written in the update state that follows.
// A stalled response holds the table in its update cycle until the output register frees.
// The response register lets the next request be accepted while a response still waits.
// Reset clears the entry count and the handshake state; cell contents are left as they are.
module key_value_table_compacting_top (
    input logic           i_clk,
    input logic           i_rst_n,
    kvt_req_if.sink       i_req,
    kvt_rsp_if.source     o_rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_ACT
    } t_state;

    localparam int CAP = kvt_pkg::CAPACITY;

    t_state               r_state;
    kvt_pkg::t_req        r_req;
    kvt_pkg::t_rsp        r_rsp;
    logic                 r_out_valid;
    kvt_pkg::t_count      r_count;

    kvt_pkg::t_count      n_count;
    kvt_pkg::t_rsp        n_rsp;
    kvt_pkg::t_cell_ctl   w_ctl;
    logic                 w_accept;
    logic                 w_act_fire;
    logic                 w_found;
    logic                 w_full;
    logic signed [kvt_pkg::VAL_W-1:0] w_found_value;

    logic signed [kvt_pkg::KEY_W-1:0] w_key   [CAP+1];
    logic signed [kvt_pkg::VAL_W-1:0] w_value [CAP+1];
    logic [CAP-1:0]       w_hit;
    logic [CAP:0]         w_chain;
    logic [CAP-1:0]       w_in_range;
    logic [CAP-1:0]       w_is_tail;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_act_fire = (r_state == ST_ACT) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // The cell past the end hands nothing useful down the row.
    assign w_key[CAP]   = '0;
    assign w_value[CAP] = '0;
    assign w_chain[0]   = 1'b0;

    // Row of cells, each fed by its upper neighbor.
    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        assign w_in_range[gi] = (r_count > kvt_pkg::CNT_W'(gi));
        assign w_is_tail[gi]  = (r_count == kvt_pkg::CNT_W'(gi));

        kvt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (w_accept ? i_req.data.key : r_req.key),
            .i_value      (r_req.value),
            .i_in_range   (w_in_range[gi]),
            .i_is_tail    (w_is_tail[gi]),
            .i_next_key   (w_key[gi+1]),
            .i_next_value (w_value[gi+1]),
            .i_prior_hit  (w_chain[gi]),
            .o_key        (w_key[gi]),
            .o_value      (w_value[gi]),
            .o_hit        (w_hit[gi]),
            .o_hit_chain  (w_chain[gi+1])
        );
    end

    // Pick the value of the matching cell; at most one cell matches.
    always_comb begin
        w_found_value = '0;
        for (int i = 0; i < CAP; i++) begin
            w_found_value = w_found_value | (w_hit[i] ? w_value[i] : '0);
        end
    end

    assign w_found = |w_hit;

    // Decide the update and build the response.
    always_comb begin
        w_ctl        = '0;
        w_ctl.cmp_en = w_accept;
        w_full       = 1'b0;
        n_count      = r_count;
        unique case (r_req.operation)
            kvt_pkg::OP_ADD: begin
                if (w_found) begin
                    w_ctl.add_update = w_act_fire;
                end else if (r_count == kvt_pkg::CNT_W'(CAP)) begin
                    w_full = 1'b1;
                end else begin
                    w_ctl.append = w_act_fire;
                    n_count      = r_count + kvt_pkg::CNT_W'(1);
                end
            end
            kvt_pkg::OP_SEARCH: begin
            end
            kvt_pkg::OP_REMOVE: begin
                if (w_found) begin
                    w_ctl.shift = w_act_fire;
                    n_count     = r_count - kvt_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        n_rsp.found       = w_found && (r_req.operation != kvt_pkg::OP_NOP);
        n_rsp.value_out   = n_rsp.found ? w_found_value : '0;
        n_rsp.full_res    = w_full;
        n_rsp.entry_count = kvt_pkg::ECNT_W'(n_count);
        n_rsp.empty_res   = (n_count == '0);
    end

    // State, request capture, count and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_req   <= i_req.data;
                r_state <= ST_ACT;
            end else if (w_act_fire) begin
                r_state <= ST_IDLE;
            end
            if (w_act_fire) begin
                r_count     <= n_count;
                r_rsp       <= n_rsp;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // Keys are unique, so at most one cell can match.
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACT) |-> $onehot0(w_hit))
        else $error("more than one cell matched the key");

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kvt_pkg::CNT_W'(CAP))
        else $error("entry count above capacity");

    // A refused add leaves the table size untouched.
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_act_fire && w_full) |=> $stable(r_count))
        else $error("refused add changed the entry count");

    // A response never reports both a match and a full table.
    a_found_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.data.found && o_rsp.data.full_res))
        else $error("response flags both found and full");
`endif

endmodule

// File: design/kvt_cell.sv
// One table cell: holds a key and a value, compares the key and shifts from its neighbor.
module kvt_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kvt_pkg::t_cell_ctl               i_ctl,
    input  logic signed [kvt_pkg::KEY_W-1:0] i_key,
    input  logic signed [kvt_pkg::VAL_W-1:0] i_value,
    input  logic                             i_in_range,
    input  logic                             i_is_tail,
    input  logic signed [kvt_pkg::KEY_W-1:0] i_next_key,
    input  logic signed [kvt_pkg::VAL_W-1:0] i_next_value,
    input  logic                             i_prior_hit,
    output logic signed [kvt_pkg::KEY_W-1:0] o_key,
    output logic signed [kvt_pkg::VAL_W-1:0] o_value,
    output logic                             o_hit,
    output logic                             o_hit_chain
);

    logic signed [kvt_pkg::KEY_W-1:0] r_key;
    logic signed [kvt_pkg::VAL_W-1:0] r_value;
    logic                             r_hit;
    logic                             w_at_or_after;

    assign w_at_or_after = i_prior_hit | r_hit;

    // Match flag, taken when a request is accepted and held until the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_hit <= i_in_range && (i_key == r_key);
        end
    end

    // Entry storage: update in place, append at the tail or shift down on remove.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift && w_at_or_after) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end else if (i_ctl.append && i_is_tail) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.add_update && r_hit) begin
            r_value <= i_value;
        end
    end

    assign o_key       = r_key;
    assign o_value     = r_value;
    assign o_hit       = r_hit;
    assign o_hit_chain = w_at_or_after;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the compacting key-value table: directed and random traffic.
module tb;
    import kvt_pkg::*;

    localparam int MAX_GAP      = 17;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = 100;
    localparam int POOL_SIZE    = 12;

    // Shadow copy of the table; predicts each response and checks it in order.
    class kvt_table_shadow;
        logic signed [KEY_W-1:0] keys [CAPACITY];
        logic signed [VAL_W-1:0] vals [CAPACITY];
        int   count;
        int   errors;
        t_rsp pending [$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Position of the key among the live entries, or -1 when absent.
        function int locate(logic signed [KEY_W-1:0] key);
            for (int i = 0; i < count; i++) begin
                if (keys[i] == key) return i;
            end
            return -1;
        endfunction

        // Applies an accepted request to the shadow table and queues its response.
        function void note_request(t_req r);
            t_rsp want;
            int   pos;
            want = '0;
            pos  = locate(r.key);
            case (r.operation)
                OP_ADD: begin
                    if (pos >= 0) begin
                        want.found     = 1'b1;
                        want.value_out = vals[pos];
                        vals[pos]      = r.value;
                    end else if (count == CAPACITY) begin
                        want.full_res = 1'b1;
                    end else begin
                        keys[count] = r.key;
                        vals[count] = r.value;
                        count++;
                    end
                end
                OP_SEARCH: begin
                    if (pos >= 0) begin
                        want.found     = 1'b1;
                        want.value_out = vals[pos];
                    end
                end
                OP_REMOVE: begin
                    if (pos >= 0) begin
                        want.found     = 1'b1;
                        want.value_out = vals[pos];
                        // Later entries move down one place to keep the table packed.
                        for (int j = pos; j < count - 1; j++) begin
                            keys[j] = keys[j + 1];
                            vals[j] = vals[j + 1];
                        end
                        count--;
                    end
                end
                default: ;
            endcase
            want.entry_count = ECNT_W'(count);
            want.empty_res   = (count == 0);
            pending.push_back(want);
        endfunction

        function void report_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Compares a delivered response with the oldest prediction.
        function void check_response(t_rsp got);
            t_rsp want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %0h", $time, got);
                return;
            end
            want = pending.pop_front();
            report_field("found", VAL_W'(want.found), VAL_W'(got.found));
            report_field("value_out", want.value_out, got.value_out);
            report_field("full_res", VAL_W'(want.full_res), VAL_W'(got.full_res));
            report_field("entry_count", VAL_W'(want.entry_count), VAL_W'(got.entry_count));
            report_field("empty_res", VAL_W'(want.empty_res), VAL_W'(got.empty_res));
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kvt_req_if req_if ();
    kvt_rsp_if rsp_if ();

    key_value_table_compacting_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    kvt_table_shadow shadow;
    bit req_burst;
    bit rsp_burst;
    bit rsp_hold_req;
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    always #1 i_clk = ~i_clk;

    // Idle gap before the next transaction, drawn at random up to MAX_GAP; skipped during a burst.
    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offers one request after the given gap and records it once accepted.
    task automatic send_request(input t_req r, input int gap);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        shadow.note_request(r);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                         input logic signed [VAL_W-1:0] value);
        t_req r;
        r.operation = op;
        r.key       = key;
        r.value     = value;
        send_request(r, draw_gap(req_burst));
    endtask

    // Stops offering requests until every predicted response has arrived.
    task automatic wait_all_responses();
        req_if.valid <= 1'b0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, every operation, full and empty table, updates and compaction.
    task automatic run_directed();
        issue(OP_SEARCH, 32'h0000_0000, 32'h0000_0001);
        issue(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
        issue(OP_NOP,    32'h0000_0000, 32'h0000_0000);
        issue(OP_ADD,    32'h8000_0000, 32'h7FFF_FFFF);
        issue(OP_ADD,    32'h7FFF_FFFF, 32'h8000_0000);
        issue(OP_ADD,    32'h0000_0000, 32'h0000_0000);
        issue(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_ADD,    32'h8000_0000, 32'h1234_5678);
        for (int k = 1; k <= CAPACITY - 4; k++) issue(OP_ADD, k, 32'h100 * k);
        issue(OP_ADD,    32'h0000_0005, 32'h0000_0005);
        issue(OP_ADD,    32'h0000_0002, 32'hA5A5_A5A5);
        issue(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(OP_SEARCH, 32'h7FFF_FFFE, 32'h0000_0000);
        issue(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
        issue(OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
        issue(OP_REMOVE, 32'h0000_0004, 32'h0000_0000);
        issue(OP_REMOVE, 32'h0000_0004, 32'h0000_0000);
        issue(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
        issue(OP_ADD,    32'h0000_0006, 32'h0000_0006);
    endtask

    // Each phase is biased at random toward filling or draining the table from a small key pool.
    task automatic run_random();
        int pick;
        bit fill_bias;
        logic [OP_W-1:0] op;
        logic signed [KEY_W-1:0] key;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
            fill_bias = $urandom_range(0, 1);
            req_burst = (phase == 2) || ($urandom_range(0, 3) == 0);
            // One phase runs back to back against a long receiver hold-off.
            if (phase == 2) rsp_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (fill_bias) begin
                    op = pick < 55 ? OP_ADD : pick < 75 ? OP_SEARCH :
                         pick < 96 ? OP_REMOVE : OP_NOP;
                end else begin
                    op = pick < 25 ? OP_ADD : pick < 45 ? OP_SEARCH :
                         pick < 96 ? OP_REMOVE : OP_NOP;
                end
                if ($urandom_range(0, 9) == 0) key = $urandom;
                else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                issue(op, key, $urandom);
            end
            if ($urandom_range(0, 2) == 0) wait_all_responses();
        end
    endtask

    // Stimulus and end of run.
    initial begin
        shadow       = new();
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_all_responses();
        run_random();
        wait_all_responses();
        repeat (20) @(posedge i_clk);
        if (shadow.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Response side: random stalls, bursts of full readiness and one long hold-off.
    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                stall        = LONG_HOLD;
            end else begin
                if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
                stall = draw_gap(rsp_burst);
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            shadow.check_response(rsp_if.data);
        end
    end

    // Watchdog.
    initial begin
        #400000;
        $display("tb: errors");
        $finish;
    end
endmodule
